/* hdl/pscq_pkg.sv */
// Shared types and codes for the per-source command queue.
// No dependencies; every other file in hdl/ imports this package.
package pscq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_CLR_SRC = 2'd2,
    OP_CLR_ALL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_STALE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_SEQ_REJ = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_NO_CMD  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ_CHK,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] gen;
    logic [31:0] seq;
    logic [31:0] tag;
    logic [63:0] body;
  } entry_t;

  // Command as classified by the front end.
  typedef struct packed {
    op_t    op;
    logic   ok;
    logic   cur;
    logic   in_range;
    entry_t ent;
  } cmd_t;

endpackage

/* hdl/pscq_front.sv */
// Front end: takes commands, decodes action and slot range, and holds them in
// a two-entry queue for the back end. Depends on pscq_pkg.
module pscq_front #(
  parameter int FIRST_SLOT = 1,
  parameter int LAST_SLOT  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic               in_command_ok,
  input  logic               in_source_current,
  input  logic [7:0]         in_source_slot,
  input  logic [31:0]        in_source_generation,
  input  logic [31:0]        in_seq_number,
  input  logic [31:0]        in_life_tag,
  input  logic [63:0]        in_body,
  output logic               cmd_valid,
  output pscq_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import pscq_pkg::*;

  cmd_t       fifo_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cls;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rptr_r];

  always_comb begin
    cls.op       = op_t'(in_action);
    cls.ok       = in_command_ok;
    cls.cur      = in_source_current;
    cls.in_range = (int'(in_source_slot) >= FIRST_SLOT) && (int'(in_source_slot) <= LAST_SLOT);
    cls.ent.slot = in_source_slot;
    cls.ent.gen  = in_source_generation;
    cls.ent.seq  = in_seq_number;
    cls.ent.tag  = in_life_tag;
    cls.ent.body = in_body;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

/* hdl/pscq_back.sv */
// Back end: queue storage, per-slot sequence table and the sequencer that
// runs enqueue, dequeue and clear commands. Depends on pscq_pkg.
module pscq_back #(
  parameter int QUEUE_DEPTH = 64,
  parameter int FIRST_SLOT  = 1,
  parameter int LAST_SLOT   = 64,
  localparam int OW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  pscq_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  output pscq_pkg::status_t   res_status,
  output pscq_pkg::entry_t    res_ent,
  output logic [OW-1:0]       res_held
);
  import pscq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NT = (LAST_SLOT >= FIRST_SLOT) ? (LAST_SLOT - FIRST_SLOT + 1) : 1;
  localparam int TW = (NT > 1) ? $clog2(NT) : 1;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] rd_r, rd_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic          pv_r, pv_nxt;
  logic          found_r, found_nxt;
  entry_t        dq_r, dq_nxt;
  logic [NT-1:0] seen_r, seen_nxt;

  logic          res_valid_r, res_valid_nxt;
  status_t       res_status_r, res_status_nxt;
  entry_t        res_ent_r, res_ent_nxt;
  logic [OW-1:0] res_held_r, res_held_nxt;

  entry_t        qmem [QUEUE_DEPTH];
  entry_t        mem_q;
  logic [63:0]   tmem [NT];
  logic [63:0]   tbl_q;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          tbl_we;
  logic [7:0]    diff_in, diff_r;
  logic [TW-1:0] tidx_in, tidx_r;

  logic          enq_pass, seq_bad, match, remove, scan_done;

  assign diff_in  = cmd.ent.slot - 8'(FIRST_SLOT);
  assign diff_r   = cmd_r.ent.slot - 8'(FIRST_SLOT);
  assign tidx_in  = diff_in[TW-1:0];
  assign tidx_r   = diff_r[TW-1:0];
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;

  assign enq_pass  = cmd.ok && cmd.cur && (occ_r < OW'(QUEUE_DEPTH)) && cmd.in_range;
  assign seq_bad   = seen_r[tidx_r] && (tbl_q[63:32] == cmd_r.ent.gen) &&
                     !(cmd_r.ent.seq > tbl_q[31:0]);
  assign match     = (mem_q.slot == cmd_r.ent.slot) && (mem_q.gen == cmd_r.ent.gen);
  assign remove    = pv_r && match && ((cmd_r.op == OP_CLR_SRC) || !found_r);
  assign scan_done = !pv_r && (rd_r == occ_r);
  assign mem_re    = (state_r == S_SCAN) && (rd_r < occ_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ENQ:     state_nxt = enq_pass ? S_ENQ_CHK : S_IDLE;
            OP_DEQ:     state_nxt = (occ_r == '0) ? S_IDLE : S_SCAN;
            OP_CLR_SRC: state_nxt = S_SCAN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENQ_CHK: state_nxt = S_IDLE;
      S_SCAN:    state_nxt = scan_done ? S_IDLE : S_SCAN;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and results
  always_comb begin
    cmd_nxt        = cmd_r;
    occ_nxt        = occ_r;
    rd_nxt         = rd_r;
    k_nxt          = k_r;
    pv_nxt         = pv_r;
    found_nxt      = found_r;
    dq_nxt         = dq_r;
    seen_nxt       = seen_r;
    mem_we         = 1'b0;
    mem_waddr      = occ_r[AW-1:0];
    mem_wdata      = cmd_r.ent;
    tbl_we         = 1'b0;
    res_valid_nxt  = 1'b0;
    res_status_nxt = ST_OK;
    res_held_nxt   = occ_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          dq_nxt    = '0;
          rd_nxt    = '0;
          k_nxt     = '0;
          pv_nxt    = 1'b0;
          found_nxt = 1'b0;
          case (cmd.op)
            OP_ENQ: begin
              res_valid_nxt = !enq_pass;
              if (!cmd.ok) begin
                res_status_nxt = ST_INVALID;
              end else if (!cmd.cur) begin
                res_status_nxt = ST_STALE;
              end else if (occ_r >= OW'(QUEUE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_status_nxt = ST_SEQ_REJ;
              end
            end
            OP_DEQ: begin
              res_valid_nxt  = (occ_r == '0);
              res_status_nxt = ST_EMPTY;
            end
            OP_CLR_SRC: begin
            end
            default: begin
              occ_nxt       = '0;
              seen_nxt      = '0;
              res_valid_nxt = 1'b1;
              res_held_nxt  = '0;
            end
          endcase
        end
      end
      S_ENQ_CHK: begin
        res_valid_nxt = 1'b1;
        if (seq_bad) begin
          res_status_nxt = ST_SEQ_REJ;
        end else begin
          mem_we           = 1'b1;
          tbl_we           = 1'b1;
          seen_nxt[tidx_r] = 1'b1;
          occ_nxt          = occ_r + 1'b1;
          res_held_nxt     = occ_r + 1'b1;
        end
      end
      S_SCAN: begin
        // compact in place: keep entries move down to the write index
        if (pv_r) begin
          if (remove) begin
            if (cmd_r.op == OP_DEQ) begin
              dq_nxt    = mem_q;
              found_nxt = 1'b1;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = k_r[AW-1:0];
            mem_wdata = mem_q;
            k_nxt     = k_r + 1'b1;
          end
        end
        if (mem_re) begin
          rd_nxt = rd_r + 1'b1;
        end
        pv_nxt = mem_re;
        if (scan_done) begin
          occ_nxt        = k_r;
          res_valid_nxt  = 1'b1;
          res_held_nxt   = k_r;
          res_status_nxt = ((cmd_r.op == OP_DEQ) && !found_r) ? ST_NO_CMD : ST_OK;
        end
      end
      default: begin
      end
    endcase
    res_ent_nxt = dq_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= qmem[rd_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tmem[tidx_r] <= {cmd_r.ent.gen, cmd_r.ent.seq};
    end
    if (cmd_pop) begin
      tbl_q <= tmem[tidx_in];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    dq_r         <= dq_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    res_held_r   <= res_held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rd_r        <= '0;
      k_r         <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      seen_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_r        <= rd_nxt;
      k_r         <= k_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      seen_r      <= seen_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_ent    = res_ent_r;
  assign res_held   = res_held_r;

endmodule

/* hdl/per_source_command_queue_top.sv */
// Back end idle: an accepted enqueue passes the sequence check before out_valid;
// rejects, empty dequeue and clear-all answer from idle; dequeue and clear-source
// scan all held entries first. The back end runs one command at a time, set by
// the walk over queue memory; a two-entry front queue absorbs commands meanwhile.
// Reset (rst_n low, synchronous) empties the queue and the sequence table.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module per_source_command_queue_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int FIRST_SLOT  = 1,
  parameter int LAST_SLOT   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic        in_command_ok,
  input  logic        in_source_current,
  input  logic [7:0]  in_source_slot,
  input  logic [31:0] in_source_generation,
  input  logic [31:0] in_seq_number,
  input  logic [31:0] in_life_tag,
  input  logic [63:0] in_body,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [31:0] out_generation,
  output logic [31:0] out_seq,
  output logic [31:0] out_life_tag,
  output logic [63:0] out_body,
  output logic [6:0]  out_held_count
);
  import pscq_pkg::*;

  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  logic          cmd_valid, cmd_pop;
  cmd_t          cmd;
  status_t       res_status;
  entry_t        res_ent;
  logic [OW-1:0] res_held;

  pscq_front #(.FIRST_SLOT(FIRST_SLOT), .LAST_SLOT(LAST_SLOT)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_command_ok, .in_source_current, .in_source_slot,
    .in_source_generation, .in_seq_number, .in_life_tag, .in_body,
    .cmd_valid, .cmd, .cmd_pop
  );

  pscq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .FIRST_SLOT(FIRST_SLOT), .LAST_SLOT(LAST_SLOT)
  ) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop,
    .res_valid(out_valid), .res_status, .res_ent, .res_held
  );

  assign out_status     = res_status;
  assign out_slot       = res_ent.slot;
  assign out_generation = res_ent.gen;
  assign out_seq        = res_ent.seq;
  assign out_life_tag   = res_ent.tag;
  assign out_body       = res_ent.body;
  assign out_held_count = 7'(res_held);

endmodule

/* hdl/pscq_checker.sv */
// Port-level checks for the per-source command queue, bound to the top level.
// Depends on pscq_pkg and per_source_command_queue_top.
module pscq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_seq,
  input logic [63:0] out_body,
  input logic [6:0]  out_held_count
);
  import pscq_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result right after reset");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'(ST_NO_CMD))) else $error("illegal status");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(ST_EMPTY)) |-> (out_held_count == 7'd0))
    else $error("empty reported with commands held");

  a_data_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 3'(ST_OK)) |-> (out_body == '0) && (out_seq == '0))
    else $error("command data on a rejected result");

endmodule

bind per_source_command_queue_top pscq_checker u_pscq_checker (
  .clk, .rst_n, .out_valid, .out_status, .out_seq, .out_body, .out_held_count
);

/* verif/testbench.sv */
// Self-checking testbench for the per-source command queue.
// Depends on hdl/pscq_pkg.sv and hdl/per_source_command_queue_top.sv.
`timescale 1ns / 100ps

module testbench;
  import pscq_pkg::*;

  localparam int DEPTH = 64;
  localparam int FIRST = 1;
  localparam int LAST = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t     status;
    logic [7:0]  slot;
    logic [31:0] gen;
    logic [31:0] seq;
    logic [31:0] tag;
    logic [63:0] body;
    logic [6:0]  held;
  } reply_t;

  class queue_scoreboard;
    entry_t      cmds[$];
    logic [31:0] known_gen[256];
    logic [31:0] high_seq[256];
    bit          known[256];
    reply_t      pending[$];
    int          errors;

    function void wipe_table();
      foreach (known[i]) begin
        known[i] = 0;
        known_gen[i] = '0;
        high_seq[i] = '0;
      end
    endfunction

    // Work out the reply for one accepted command and queue it.
    function void note_command(op_t op, bit ok, bit cur, logic [7:0] slot,
                               logic [31:0] gen, logic [31:0] seq,
                               logic [31:0] tag, logic [63:0] body);
      reply_t r;
      entry_t e;
      int idx;
      int t;
      r = '{ST_OK, '0, '0, '0, '0, '0, '0};
      case (op)
        OP_ENQ: begin
          t = (int'(slot) - FIRST) & 255;
          if (!ok) r.status = ST_INVALID;
          else if (!cur) r.status = ST_STALE;
          else if (cmds.size() >= DEPTH) r.status = ST_FULL;
          else if (slot < FIRST || slot > LAST) r.status = ST_SEQ_REJ;
          else if (known[t] && known_gen[t] == gen && !(seq > high_seq[t]))
            r.status = ST_SEQ_REJ;
          else begin
            e = '{slot, gen, seq, tag, body};
            cmds.push_back(e);
            known[t] = 1;
            known_gen[t] = gen;
            high_seq[t] = seq;
          end
        end
        OP_DEQ: begin
          idx = -1;
          foreach (cmds[i])
            if (idx < 0 && cmds[i].slot == slot && cmds[i].gen == gen) idx = i;
          if (cmds.size() == 0) r.status = ST_EMPTY;
          else if (idx < 0) r.status = ST_NO_CMD;
          else begin
            r.slot = cmds[idx].slot;
            r.gen = cmds[idx].gen;
            r.seq = cmds[idx].seq;
            r.tag = cmds[idx].tag;
            r.body = cmds[idx].body;
            cmds.delete(idx);
          end
        end
        OP_CLR_SRC: begin
          for (int i = cmds.size() - 1; i >= 0; i--)
            if (cmds[i].slot == slot && cmds[i].gen == gen) cmds.delete(i);
        end
        default: begin
          cmds.delete();
          wipe_table();
        end
      endcase
      r.held = 7'(cmds.size());
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, got.status);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.status !== got.status || w.slot !== got.slot || w.gen !== got.gen ||
          w.seq !== got.seq || w.tag !== got.tag || w.body !== got.body ||
          w.held !== got.held) begin
        $display("%0t: expected st=%0d slot=%0h gen=%0h seq=%0h tag=%0h body=%0h held=%0d",
                 $time, w.status, w.slot, w.gen, w.seq, w.tag, w.body, w.held);
        $display("%0t: actual   st=%0d slot=%0h gen=%0h seq=%0h tag=%0h body=%0h held=%0d",
                 $time, got.status, got.slot, got.gen, got.seq, got.tag, got.body,
                 got.held);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_action = '0;
  logic in_command_ok = 0;
  logic in_source_current = 0;
  logic [7:0] in_source_slot = '0;
  logic [31:0] in_source_generation = '0;
  logic [31:0] in_seq_number = '0;
  logic [31:0] in_life_tag = '0;
  logic [63:0] in_body = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [7:0] out_slot;
  logic [31:0] out_generation, out_seq, out_life_tag;
  logic [63:0] out_body;
  logic [6:0] out_held_count;

  queue_scoreboard board = new();
  int cycles = 0;
  logic [31:0] gens[4];
  logic [31:0] next_seq[256];

  per_source_command_queue_top dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    reply_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.slot = out_slot;
      got.gen = out_generation;
      got.seq = out_seq;
      got.tag = out_life_tag;
      got.body = out_body;
      got.held = out_held_count;
      board.check_reply(got);
    end
  end

  // Hold start until the transfer happens, then, when spaced, drop it for a random gap.
  task automatic issue(op_t op, bit ok, bit cur, logic [7:0] slot,
                       logic [31:0] gen, logic [31:0] seq, logic [31:0] tag,
                       logic [63:0] body, bit spaced = 1);
    int gap;
    in_action <= op;
    in_command_ok <= ok;
    in_source_current <= cur;
    in_source_slot <= slot;
    in_source_generation <= gen;
    in_seq_number <= seq;
    in_life_tag <= tag;
    in_body <= body;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_command(op, ok, cur, slot, gen, seq, tag, body);
    gap = spaced ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed commands, rising sequences, from a few sources.
  task automatic random_item(bit spaced);
    int pick;
    int sl;
    logic [31:0] g;
    logic [31:0] s;
    op_t op;
    pick = $urandom_range(0, 99);
    sl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
    g = gens[$urandom_range(0, 3)];
    if (pick < 55) op = OP_ENQ;
    else if (pick < 85) op = OP_DEQ;
    else if (pick < 97) op = OP_CLR_SRC;
    else op = OP_CLR_ALL;
    if ($urandom_range(0, 7) == 0) s = $urandom;
    else begin
      next_seq[sl] = next_seq[sl] + $urandom_range(1, 3);
      s = next_seq[sl];
    end
    issue(op, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0, sl[7:0], g, s,
          $urandom, rand64(), spaced);
  endtask

  initial begin
    gens[0] = 32'd0;
    gens[1] = 32'd1;
    gens[2] = 32'hFFFF_FFFF;
    gens[3] = $urandom;
    foreach (next_seq[i]) next_seq[i] = '0;
    board.wipe_table();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty dequeue, check order, range edges, sequence rules.
    issue(OP_DEQ, 1, 1, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_CLR_SRC, 1, 1, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_ENQ, 0, 0, 8'd0, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 0, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 1, 8'd0, 32'd0, 32'd1, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 1, 8'd65, 32'd0, 32'd1, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 1, 8'd255, 32'd0, 32'd1, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 1, 8'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, '1);
    issue(OP_ENQ, 1, 1, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_ENQ, 1, 1, 8'd1, 32'd0, 32'hFFFF_FFFF, 32'd5, 64'd5);
    issue(OP_ENQ, 1, 1, 8'd1, 32'd0, 32'hFFFF_FFFF, 32'd5, 64'd5);
    issue(OP_ENQ, 1, 1, 8'd1, 32'hFFFF_FFFF, 32'd0, 32'd6, 64'd6);
    issue(OP_ENQ, 1, 1, 8'd64, 32'hFFFF_FFFF, 32'd7, '1, '1);
    issue(OP_DEQ, 1, 1, 8'd2, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_DEQ, 1, 1, 8'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 64'd0);
    issue(OP_DEQ, 1, 1, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_CLR_SRC, 1, 1, 8'd1, 32'd0, 32'd0, 32'd0, 64'd0);
    issue(OP_DEQ, 1, 1, 8'd64, 32'hFFFF_FFFF, 32'd0, 32'd0, 64'd0);
    issue(OP_CLR_ALL, 1, 1, 8'd0, 32'd0, 32'd0, 32'd0, 64'd0);
    // Fill to capacity and past it.
    for (int i = 0; i < DEPTH + 2; i++)
      issue(OP_ENQ, 1, 1, 8'(1 + i % 64), 32'd3, 32'(i + 1), $urandom, rand64(), 0);
    issue(OP_DEQ, 1, 1, 8'd64, 32'd3, 32'd0, 32'd0, 64'd0);
    issue(OP_CLR_ALL, 1, 1, 8'd0, 32'd0, 32'd0, 32'd0, 64'd0);
    // Pause until every expected result is in.
    drain();

    for (int n = 0; n < 1700; n++) random_item(n % 200 >= 40);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
